// ----- src/swam_pkg.sv -----
`timescale 1ns / 1ps

package swam_pkg;

  // Fixed widths of the channel fields.
  localparam int BYTE_W = 8;
  localparam int FUNC_W = 2;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd2;

  typedef struct packed {
    logic window_match;
    logic found_so_far;
    logic pattern_overflow;
  } result_t;

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_PADD = 5'b00100,
    ST_TSUB = 5'b01000,
    ST_TADD = 5'b10000
  } state_t;

endpackage

// ----- src/swam_if.sv -----
`timescale 1ns / 1ps

interface swam_in_if;
  import swam_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink (input valid, input func, input symbol, output ready);
endinterface

interface swam_out_if;
  logic valid;
  logic ready;
  logic window_match;
  logic found_so_far;
  logic pattern_overflow;

  modport source (output valid, output window_match, output found_so_far,
                  output pattern_overflow, input ready);
  modport sink (input valid, input window_match, input found_so_far,
                input pattern_overflow, output ready);
endinterface

// ----- src/swam_ram.sv -----
`timescale 1ns / 1ps

module swam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read returns the contents from before a write to the same address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/swam_obuf.sv -----
`timescale 1ns / 1ps

module swam_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  swam_pkg::result_t res,
  output logic              can_take,
  swam_out_if.source        out_ch
);
  import swam_pkg::*;

  logic    out_free;
  logic    pend_r, pend_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t pend_data_r, pend_data_nxt;
  result_t out_data_r, out_data_nxt;

  assign out_free = !out_valid_r || out_ch.ready;
  assign can_take = !pend_r;

  // A new result goes straight to the output register when it is free,
  // otherwise it waits in the skid slot.
  always_comb begin
    pend_nxt      = pend_r;
    pend_data_nxt = pend_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    priority if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (res_valid) begin
      pend_nxt      = 1'b1;
      pend_data_nxt = res;
    end else if (pend_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pend_data_r;
      pend_nxt      = 1'b0;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_data_r <= pend_data_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.window_match     = out_data_r.window_match;
  assign out_ch.found_so_far     = out_data_r.found_so_far;
  assign out_ch.pattern_overflow = out_data_r.pattern_overflow;

endmodule

// ----- src/sliding_window_anagram_matcher_top.sv -----
// Sliding window anagram matcher.
// The input channel in_ch carries func and symbol. A clear item starts a new
// search, pattern items add one symbol to the pattern, and text items slide
// a window of pattern length over the text. Every accepted item yields one
// transfer on out_ch: window_match (the window ending at this text byte is a
// permutation of the pattern), the sticky found_so_far and the sticky
// pattern_overflow flag.
// Per-symbol differences live in one synchronous RAM and the recent text in
// a ring RAM; each update is a read-modify-write through the difference RAM.
// A text byte with a full window takes a read, then one write-back for the
// incoming symbol and one for the leaving symbol; a text byte while the
// window fills and a pattern byte take a read and one write-back; an
// overflowed pattern byte or the unused code is answered as it is accepted.
// The result passes through the output register before it appears on out_ch.
// A clear item walks the difference RAM, one entry a cycle, before its
// result is given. After reset the same clearing pass runs with in_ch.ready
// low.
// When out_ch stalls, one more result is held in a skid slot; after that
// in_ch.ready stays low until the receiver takes a transfer.
`timescale 1ns / 1ps

module sliding_window_anagram_matcher_top #(
  parameter int MAX_PATTERN = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  swam_in_if.sink    in_ch,
  swam_out_if.source out_ch
);
  import swam_pkg::*;

  localparam int NUM_SYM = 1 << SYMBOL_BITS;
  localparam int SYM_W   = SYMBOL_BITS;
  localparam int PTR_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int DIFF_W  = LEN_W + 1;
  localparam int NZ_W    = $clog2(NUM_SYM + 1);

  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_PATTERN);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_PATTERN - 1);
  localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(NUM_SYM - 1);

  // Moves the count of differing symbols when one entry changes.
  function automatic logic [NZ_W-1:0] nz_adjust(input logic [NZ_W-1:0] cnt,
                                                input logic was_zero,
                                                input logic is_zero);
    logic [NZ_W-1:0] res;
    res = cnt;
    if (was_zero && !is_zero) begin
      res = cnt + NZ_W'(1);
    end else if (!was_zero && is_zero) begin
      res = cnt - NZ_W'(1);
    end
    return res;
  endfunction

  // Control state.
  state_t            state_r, state_nxt;
  logic [SYM_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              clr_emit_r, clr_emit_nxt;
  logic [NZ_W-1:0]   nz_r, nz_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [LEN_W-1:0]  pl_r, pl_nxt;
  logic [LEN_W-1:0]  tf_r, tf_nxt;
  logic              found_r, found_nxt;
  logic              ovf_r, ovf_nxt;

  // Per-item working registers.
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              full_r, full_nxt;
  logic              use_ring_r, use_ring_nxt;
  logic [SYM_W-1:0]  leave_r, leave_nxt;
  logic [DIFF_W-1:0] fwd_r, fwd_nxt;
  logic              same_r, same_nxt;

  // Memory ports.
  logic              diff_we;
  logic [SYM_W-1:0]  diff_waddr, diff_raddr;
  logic [DIFF_W-1:0] diff_wdata, diff_rdata;
  logic              ring_we;
  logic [PTR_W-1:0]  ring_raddr;
  logic [BYTE_W-1:0] ring_rdata;

  // Datapath values.
  logic              in_fire;
  logic              can_take;
  logic              res_valid;
  result_t           res;
  logic [DIFF_W-1:0] d_old, d_new;
  logic [NZ_W-1:0]   nz_mid;
  logic [SYM_W-1:0]  leaving;
  logic              match;
  logic [LEN_W-1:0]  tf_inc;
  logic [LEN_W-1:0]  wp_ext, ring_back;

  assign in_ch.ready = (state_r == ST_IDLE) && can_take;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The slot leaving the window sits pattern_length places behind the write
  // pointer, modulo the ring depth.
  assign wp_ext     = LEN_W'(wp_r);
  assign ring_back  = (wp_ext >= pl_r) ? (wp_ext - pl_r) : (wp_ext + LEN_MAX - pl_r);
  assign ring_raddr = ring_back[PTR_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_emit_nxt = clr_emit_r;
    nz_nxt       = nz_r;
    wp_nxt       = wp_r;
    pl_nxt       = pl_r;
    tf_nxt       = tf_r;
    found_nxt    = found_r;
    ovf_nxt      = ovf_r;
    sym_nxt      = sym_r;
    byte_nxt     = byte_r;
    full_nxt     = full_r;
    use_ring_nxt = use_ring_r;
    leave_nxt    = leave_r;
    fwd_nxt      = fwd_r;
    same_nxt     = same_r;

    diff_we    = 1'b0;
    diff_waddr = sym_r;
    diff_wdata = '0;
    diff_raddr = in_ch.symbol[SYM_W-1:0];
    ring_we    = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    d_old      = diff_rdata;
    d_new      = '0;
    nz_mid     = nz_r;
    leaving    = sym_r;
    match      = 1'b0;
    tf_inc     = tf_r + LEN_W'(1);

    unique case (state_r)
      ST_CLR: begin
        // Clearing pass: zero one difference entry per cycle.
        diff_we    = 1'b1;
        diff_waddr = clr_cnt_r;
        if (clr_cnt_r == SYM_LAST) begin
          state_nxt = ST_IDLE;
          res_valid = clr_emit_r;
        end else begin
          clr_cnt_nxt = clr_cnt_r + SYM_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          sym_nxt      = in_ch.symbol[SYM_W-1:0];
          byte_nxt     = in_ch.symbol;
          full_nxt     = (tf_r >= pl_r);
          use_ring_nxt = (tf_r >= pl_r) && (pl_r != '0);
          unique case (in_ch.func)
            FUNC_CLEAR: begin
              nz_nxt       = '0;
              wp_nxt       = '0;
              pl_nxt       = '0;
              tf_nxt       = '0;
              found_nxt    = 1'b0;
              ovf_nxt      = 1'b0;
              clr_cnt_nxt  = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = ST_CLR;
            end
            FUNC_PATTERN: begin
              if (pl_r == LEN_MAX) begin
                // Pattern is at capacity: drop the byte and flag it.
                ovf_nxt   = 1'b1;
                res_valid = 1'b1;
                res       = '{window_match: 1'b0, found_so_far: found_r,
                              pattern_overflow: 1'b1};
              end else begin
                state_nxt = ST_PADD;
              end
            end
            FUNC_TEXT: begin
              state_nxt = ST_TSUB;
            end
            default: begin
              res_valid = 1'b1;
              res       = '{window_match: 1'b0, found_so_far: found_r,
                            pattern_overflow: ovf_r};
            end
          endcase
        end
      end

      ST_PADD: begin
        d_new      = d_old + DIFF_W'(1);
        diff_we    = 1'b1;
        diff_waddr = sym_r;
        diff_wdata = d_new;
        nz_nxt     = nz_adjust(nz_r, d_old == '0, d_new == '0);
        pl_nxt     = pl_r + LEN_W'(1);
        res_valid  = 1'b1;
        res        = '{window_match: 1'b0, found_so_far: found_r,
                       pattern_overflow: ovf_r};
        state_nxt  = ST_IDLE;
      end

      ST_TSUB: begin
        // Incoming symbol leaves one count; the text byte enters the ring.
        d_new      = d_old - DIFF_W'(1);
        diff_we    = 1'b1;
        diff_waddr = sym_r;
        diff_wdata = d_new;
        nz_mid     = nz_adjust(nz_r, d_old == '0, d_new == '0);
        nz_nxt     = nz_mid;
        ring_we    = 1'b1;
        wp_nxt     = (wp_r == PTR_LAST) ? '0 : (wp_r + PTR_W'(1));
        leaving    = use_ring_r ? ring_rdata[SYM_W-1:0] : sym_r;
        diff_raddr = leaving;
        leave_nxt  = leaving;
        fwd_nxt    = d_new;
        same_nxt   = (leaving == sym_r);
        if (full_r) begin
          state_nxt = ST_TADD;
        end else begin
          tf_nxt    = tf_inc;
          match     = (tf_inc >= pl_r) && (nz_mid == '0);
          found_nxt = found_r || match;
          res_valid = 1'b1;
          res       = '{window_match: match, found_so_far: found_r || match,
                        pattern_overflow: ovf_r};
          state_nxt = ST_IDLE;
        end
      end

      ST_TADD: begin
        // The RAM read was issued before the last write; forward it when
        // the leaving symbol is the one just written.
        d_old      = same_r ? fwd_r : diff_rdata;
        d_new      = d_old + DIFF_W'(1);
        diff_we    = 1'b1;
        diff_waddr = leave_r;
        diff_wdata = d_new;
        nz_mid     = nz_adjust(nz_r, d_old == '0, d_new == '0);
        nz_nxt     = nz_mid;
        match      = (nz_mid == '0);
        found_nxt  = found_r || match;
        res_valid  = 1'b1;
        res        = '{window_match: match, found_so_far: found_r || match,
                       pattern_overflow: ovf_r};
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt    = ST_CLR;
        clr_cnt_nxt  = '0;
        clr_emit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_cnt_r  <= '0;
      clr_emit_r <= 1'b0;
      nz_r       <= '0;
      wp_r       <= '0;
      pl_r       <= '0;
      tf_r       <= '0;
      found_r    <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      clr_emit_r <= clr_emit_nxt;
      nz_r       <= nz_nxt;
      wp_r       <= wp_nxt;
      pl_r       <= pl_nxt;
      tf_r       <= tf_nxt;
      found_r    <= found_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    byte_r     <= byte_nxt;
    full_r     <= full_nxt;
    use_ring_r <= use_ring_nxt;
    leave_r    <= leave_nxt;
    fwd_r      <= fwd_nxt;
    same_r     <= same_nxt;
  end

  swam_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (NUM_SYM)
  ) u_diff_ram (
    .clk     (clk),
    .wr_en   (diff_we),
    .wr_addr (diff_waddr),
    .wr_data (diff_wdata),
    .rd_addr (diff_raddr),
    .rd_data (diff_rdata)
  );

  swam_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (wp_r),
    .wr_data (byte_r),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  swam_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_ch    (out_ch)
  );

endmodule

// ----- src/swam_chk.sv -----
`timescale 1ns / 1ps

module swam_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [swam_pkg::FUNC_W-1:0] in_func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_window_match,
  input logic                        out_found_so_far,
  input logic                        out_pattern_overflow
);
  import swam_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_match) &&
      $stable(out_found_so_far) && $stable(out_pattern_overflow))
    else $error("result changed while stalled");

  // A matching window always shows up in the sticky flag.
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_match |-> out_found_so_far)
    else $error("window match without found flag");

  // Reset starts the clearing pass: nothing taken, nothing offered.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block active right after reset");

  // A clear transfer starts the store walk, which holds off new input.
  a_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_CLEAR) |=> !in_ready)
    else $error("input taken during clearing pass");

endmodule

bind sliding_window_anagram_matcher_top swam_chk u_swam_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .in_func              (in_ch.func),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_window_match     (out_ch.window_match),
  .out_found_so_far     (out_ch.found_so_far),
  .out_pattern_overflow (out_ch.pattern_overflow)
);

// ----- tb/sv/swam_checker.sv -----
`timescale 1ns / 1ps

module swam_checker #(
  parameter int MAX_PATTERN = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  swam_in_if   in_ch,
  swam_out_if  out_ch,
  output int   mismatches,
  output int   queued,
  output int   results_checked,
  output int   text_seen,
  output int   matches_seen,
  output int   overflow_seen
);
  import swam_pkg::*;

  localparam int NUM_SYMS = 1 << SYMBOL_BITS;
  localparam int SYM_MASK = NUM_SYMS - 1;

  // Search state: per-symbol balance of pattern count minus window count.
  int                sym_balance [NUM_SYMS];
  int                unbalanced;
  logic [BYTE_W-1:0] recent_bytes [MAX_PATTERN];
  int                ring_wr;
  int                pat_len;
  int                win_fill;
  logic              found_seen;
  logic              ovf_seen;

  result_t flag_queue [$];

  function automatic void wipe_search();
    for (int i = 0; i < NUM_SYMS; i++) sym_balance[i] = 0;
    for (int i = 0; i < MAX_PATTERN; i++) recent_bytes[i] = '0;
    unbalanced = 0;
    ring_wr    = 0;
    pat_len    = 0;
    win_fill   = 0;
    found_seen = 1'b0;
    ovf_seen   = 1'b0;
  endfunction

  function automatic void bump(int sym, int delta);
    int was;
    was = sym_balance[sym];
    sym_balance[sym] = was + delta;
    if (was == 0 && sym_balance[sym] != 0) unbalanced++;
    else if (was != 0 && sym_balance[sym] == 0) unbalanced--;
  endfunction

  function automatic result_t advance_search(logic [FUNC_W-1:0] op, logic [BYTE_W-1:0] b);
    result_t r;
    int      sym;
    int      leaving;
    logic    full;
    sym = int'(b) & SYM_MASK;
    r   = '0;
    case (op)
      FUNC_CLEAR: begin
        wipe_search();
      end
      FUNC_PATTERN: begin
        if (pat_len >= MAX_PATTERN) begin
          ovf_seen = 1'b1;
        end else begin
          bump(sym, 1);
          pat_len++;
        end
      end
      FUNC_TEXT: begin
        // With an empty pattern the leaving symbol is the incoming one.
        leaving = sym;
        full    = (win_fill >= pat_len);
        if (full && pat_len != 0)
          leaving = int'(recent_bytes[(ring_wr + MAX_PATTERN - pat_len) % MAX_PATTERN])
                    & SYM_MASK;
        recent_bytes[ring_wr] = b;
        ring_wr = (ring_wr + 1) % MAX_PATTERN;
        bump(sym, -1);
        if (full) bump(leaving, 1);
        else win_fill++;
        r.window_match = (win_fill >= pat_len) && (unbalanced == 0);
        if (r.window_match) found_seen = 1'b1;
      end
      default: ;
    endcase
    r.found_so_far     = found_seen;
    r.pattern_overflow = ovf_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic want_v, logic got_v);
    $display("MISMATCH %s: expected %0b, got %0b at %0t", what, want_v, got_v, $time);
    mismatches++;
  endtask

  initial begin
    mismatches      = 0;
    results_checked = 0;
    text_seen       = 0;
    matches_seen    = 0;
    overflow_seen   = 0;
    queued          = 0;
    wipe_search();
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      wipe_search();
      flag_queue.delete();
    end else begin
      // Results first, so a result cannot pair with an item accepted on the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (flag_queue.size() == 0) begin
          report_mismatch("result transfer with nothing pending", 1'b0, out_ch.window_match);
        end else begin
          want = flag_queue.pop_front();
          results_checked++;
          if (out_ch.window_match !== want.window_match)
            report_mismatch("window_match", want.window_match, out_ch.window_match);
          if (out_ch.found_so_far !== want.found_so_far)
            report_mismatch("found_so_far", want.found_so_far, out_ch.found_so_far);
          if (out_ch.pattern_overflow !== want.pattern_overflow)
            report_mismatch("pattern_overflow", want.pattern_overflow,
                            out_ch.pattern_overflow);
          if (want.window_match) matches_seen++;
          if (want.pattern_overflow) overflow_seen++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        flag_queue.insert(flag_queue.size(), advance_search(in_ch.func, in_ch.symbol));
        if (in_ch.func == FUNC_TEXT) text_seen++;
      end
    end
    queued <= flag_queue.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import swam_pkg::*;

  localparam int MAX_PATTERN = 256;
  localparam int SYMBOL_BITS = 8;

  // The block ignores the fourth func code; it is still sent to check that.
  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

  localparam int ITEM_GOAL = 1450;

  logic clk = 1'b0;
  logic rst_n;

  int mismatches;
  int queued;
  int results_checked;
  int text_seen;
  int matches_seen;
  int overflow_seen;

  // Counts accepted items that the block acts on; reserved codes are left out.
  int   items_sent;
  // Burst flags switch off idling on either side for a stretch.
  logic in_burst;
  logic out_burst;

  swam_in_if  in_ch ();
  swam_out_if out_ch ();

  always #5 clk = ~clk;

  sliding_window_anagram_matcher_top #(
    .MAX_PATTERN(MAX_PATTERN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  swam_checker #(
    .MAX_PATTERN(MAX_PATTERN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .queued         (queued),
    .results_checked(results_checked),
    .text_seen      (text_seen),
    .matches_seen   (matches_seen),
    .overflow_seen  (overflow_seen)
  );

  // Offers one item and returns at the edge where the transfer happens. A
  // random number of idle cycles comes first, unless a burst is running.
  // While valid is low the payload carries junk so that the block cannot
  // rely on it.
  task automatic send_item(logic [FUNC_W-1:0] op, logic [BYTE_W-1:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_ch.valid  <= 1'b0;
      in_ch.func   <= FUNC_W'($urandom_range(0, 3));
      in_ch.symbol <= BYTE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= op;
    in_ch.symbol <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (op != FUNC_RESERVED) items_sent++;
  endtask

  // Draws a byte from a small alphabet around base, so that windows often
  // hold the same symbols as the pattern; now and then any byte at all.
  function automatic logic [BYTE_W-1:0] pick_byte(logic [BYTE_W-1:0] base, int alpha);
    if ($urandom_range(0, 15) == 0) return BYTE_W'($urandom);
    return base + BYTE_W'($urandom_range(0, alpha - 1));
  endfunction

  // One well formed search: clear, a pattern, then enough text to slide the
  // window across it. Most patterns are short. A rare long one fills the
  // pattern store, and may run past capacity so that bytes get dropped. Text
  // sometimes carries a shuffled copy of the pattern, so that matches are
  // common, and now and then a late pattern byte or a reserved code.
  task automatic run_search(logic force_long);
    logic [BYTE_W-1:0] pat_bytes [$];
    logic [BYTE_W-1:0] shuffled [$];
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] swap_b;
    int                alpha;
    int                plen;
    int                ntext;
    int                sel;
    int                k;
    int                j;
    int                n;
    base  = BYTE_W'($urandom);
    alpha = $urandom_range(1, 4);
    sel   = $urandom_range(0, 29);
    if (force_long) plen = 260;
    else if (sel == 0) plen = $urandom_range(250, 262);
    else if (sel < 3) plen = $urandom_range(9, 40);
    else if (sel == 3) plen = 0;
    else plen = $urandom_range(1, 8);

    send_item(FUNC_CLEAR, BYTE_W'($urandom));
    for (k = 0; k < plen; k++) begin
      pat_bytes.insert(pat_bytes.size(), pick_byte(base, alpha));
      send_item(FUNC_PATTERN, pat_bytes[k]);
    end

    ntext = ((plen > MAX_PATTERN) ? MAX_PATTERN : plen) + $urandom_range(0, 24);
    k = 0;
    while (k < ntext) begin
      if (plen != 0 && plen <= 40 && $urandom_range(0, 5) == 0) begin
        // Plant a permutation of the pattern; the window ending at its last
        // byte must match.
        shuffled = pat_bytes;
        for (j = shuffled.size() - 1; j > 0; j--) begin
          n = $urandom_range(0, j);
          swap_b      = shuffled[j];
          shuffled[j] = shuffled[n];
          shuffled[n] = swap_b;
        end
        foreach (shuffled[i]) send_item(FUNC_TEXT, shuffled[i]);
        k += shuffled.size();
      end else if ($urandom_range(0, 60) == 0) begin
        // A pattern byte after text grows the window.
        pat_bytes.insert(pat_bytes.size(), pick_byte(base, alpha));
        plen++;
        send_item(FUNC_PATTERN, pat_bytes[pat_bytes.size() - 1]);
        k++;
      end else if ($urandom_range(0, 80) == 0) begin
        send_item(FUNC_RESERVED, BYTE_W'($urandom));
      end else begin
        send_item(FUNC_TEXT, pick_byte(base, alpha));
        k++;
      end
    end
  endtask

  // Noise: any func code with any byte, including stray clears.
  task automatic send_noise();
    int n;
    n = $urandom_range(4, 16);
    repeat (n) send_item(FUNC_W'($urandom_range(0, 3)), BYTE_W'($urandom));
  endtask

  // The receiver stalls for a random number of cycles after each transfer,
  // except during a burst. Ready rises only after reset has been released.
  initial begin : result_drain
    int n;
    out_burst = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if ($urandom_range(0, 24) == 0) out_burst = !out_burst;
        n = out_burst ? 0 : $urandom_range(0, 12);
        if (n != 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int seq_no;
    items_sent = 0;
    in_burst   = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_CLEAR;
    in_ch.symbol <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. An empty pattern matches on every text byte, the first
    // one included; a reserved code changes nothing.
    send_item(FUNC_CLEAR, 8'hFF);
    send_item(FUNC_TEXT, 8'h41);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_RESERVED, 8'hAA);
    // Extreme symbols in a two byte pattern, a window that fills, matches,
    // slides and stops matching.
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_PATTERN, 8'h00);
    send_item(FUNC_PATTERN, 8'hFF);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_TEXT, 8'h7E);
    // A pattern byte after text: the window grows with the next text byte.
    send_item(FUNC_PATTERN, 8'h7E);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_RESERVED, 8'h55);
    // A clear in the middle of a search drops the sticky flag.
    send_item(FUNC_CLEAR, 8'h5A);
    send_item(FUNC_PATTERN, 8'h80);
    send_item(FUNC_TEXT, 8'h01);
    send_item(FUNC_TEXT, 8'h80);

    // Random part. The first search is long enough to overflow the pattern
    // store and wrap the text ring; the rest are mostly short searches.
    seq_no = 0;
    while (items_sent < ITEM_GOAL) begin
      in_burst = ($urandom_range(0, 3) == 0);
      if (seq_no != 0 && $urandom_range(0, 3) == 0) send_noise();
      else run_search(seq_no == 0);
      seq_no++;
    end
    in_ch.valid <= 1'b0;

    // The checker publishes its queue depth through a register, so step once
    // before waiting for it to drain; then give any stray result time to show
    // up.
    @(posedge clk);
    while (queued != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d items in %0d sequences, %0d of them text bytes.",
             items_sent, seq_no, text_seen);
    $display("Compared %0d results: %0d window matches, %0d with overflow set.",
             results_checked, matches_seen, overflow_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run (every item a clear that
  // walks the store, with the longest stalls on both sides).
  initial begin : watchdog
    #(30_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
src/swam_pkg.sv
src/swam_if.sv
src/swam_ram.sv
src/swam_obuf.sv
src/sliding_window_anagram_matcher_top.sv
src/swam_chk.sv
tb/sv/swam_checker.sv
tb/sv/tb_top.sv
